// File: rtl/core/olid_pkg.sv
// Shared constants, command and status codes, and cell control types for the ordered list.
package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // Broadcast to every cell in the chain each cycle.
    typedef struct packed {
        t_cell_op               op;
        logic [IDX_W-1:0]       idx;
        logic [CNT_W-1:0]       count;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

// File: rtl/core/olid_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
interface olid_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [olid_pkg::CMD_W-1:0]          cmd;
    logic signed [olid_pkg::VAL_W-1:0]   value;
    logic [olid_pkg::POS_W-1:0]          position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// File: rtl/core/olid_res_if.sv
// Result channel: valid/ready handshake carrying one result word.
interface olid_res_if;
    logic                                valid;
    logic                                ready;
    logic [olid_pkg::STAT_W-1:0]         status;
    logic [olid_pkg::CNT_W-1:0]          element_count;
    logic signed [olid_pkg::VAL_W-1:0]   element_value;
    logic                                last_flag;

    modport source (output valid, output status, output element_count,
                    output element_value, output last_flag, input ready);
    modport sink   (input valid, input status, input element_count,
                    input element_value, input last_flag, output ready);
endinterface

// File: rtl/core/olid_cell.sv
// One storage cell of the list chain: holds, loads, or takes a neighbor's or the head's element.
module olid_cell (
    input  logic                              i_clk,
    input  logic [olid_pkg::IDX_W-1:0]        i_index,
    input  olid_pkg::t_cell_ctl               i_ctl,
    input  logic signed [olid_pkg::VAL_W-1:0] i_left,
    input  logic signed [olid_pkg::VAL_W-1:0] i_right,
    input  logic signed [olid_pkg::VAL_W-1:0] i_head,
    output logic signed [olid_pkg::VAL_W-1:0] o_data
);

    logic signed [olid_pkg::VAL_W-1:0] r_data;
    logic signed [olid_pkg::VAL_W-1:0] n_data;
    logic [olid_pkg::CNT_W-1:0]        w_pos;
    logic [olid_pkg::CNT_W-1:0]        w_pos_p1;

    assign w_pos    = olid_pkg::CNT_W'(i_index);
    assign w_pos_p1 = w_pos + olid_pkg::CNT_W'(1);

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            olid_pkg::CELL_INSERT: begin
                // open a gap at idx: cells above it take from the left
                if (i_index == i_ctl.idx) begin
                    n_data = i_ctl.value;
                end else if (i_index > i_ctl.idx && w_pos <= i_ctl.count) begin
                    n_data = i_left;
                end
            end
            olid_pkg::CELL_DELETE: begin
                // close the gap at idx: cells from idx up take from the right
                if (i_index >= i_ctl.idx && w_pos_p1 < i_ctl.count) begin
                    n_data = i_right;
                end
            end
            olid_pkg::CELL_ROTATE: begin
                // circular step: head wraps around to the tail
                if (w_pos_p1 < i_ctl.count) begin
                    n_data = i_right;
                end else if (w_pos_p1 == i_ctl.count) begin
                    n_data = i_head;
                end
            end
            olid_pkg::CELL_HOLD: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/ordered_list_insert_delete.sv
// Top level of the bounded ordered list: command decode, cell chain and result register.
//
//  channel | dir | fields                                         | handshake
//  --------+-----+------------------------------------------------+------------
//  i_cmd   | in  | cmd[2:0], value[31:0] s, position[7:0]         | valid/ready
//  o_res   | out | status[1:0], element_count[4:0],               | valid/ready
//          |     | element_value[31:0] s, last_flag               |
//
// Insert and delete commands shift every cell of the chain in parallel in the cycle
// the command word is accepted, and the result word is registered behind it. A
// dump of N elements rotates the chain once per emitted word (the head wraps to the
// tail), so after N steps the list is back in order; no command is taken meanwhile.
// Synchronous active-low reset empties the list. A stalled result word holds, and
// outside a dump the command side stalls only while that word is still waiting and
// a new one would replace it.
module ordered_list_insert_delete (
    input  logic              i_clk,
    input  logic              i_rst_n,
    olid_cmd_if.sink          i_cmd,
    olid_res_if.source        o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state                            r_state, n_state;
    logic [olid_pkg::CNT_W-1:0]        r_count, n_count;
    logic [olid_pkg::CNT_W-1:0]        r_left, n_left;

    // result register
    logic                              r_out_valid, n_out_valid;
    olid_pkg::t_status                 r_status, n_status;
    logic [olid_pkg::CNT_W-1:0]        r_count_out, n_count_out;
    logic signed [olid_pkg::VAL_W-1:0] r_value, n_value;
    logic                              r_last, n_last;

    logic                              w_out_free;
    logic                              w_take;
    logic                              w_full;
    logic                              w_empty;
    logic [olid_pkg::POS_W-1:0]        w_pos_m1;
    logic [olid_pkg::CNT_W-1:0]        w_cnt_m1;
    logic [olid_pkg::POS_W-1:0]        w_cnt_ext;
    olid_pkg::t_cell_ctl               w_ctl;

    logic signed [olid_pkg::VAL_W-1:0] w_cell_data [olid_pkg::CAPACITY];

    // Cell chain: each cell sees its neighbors and the head for the rotate wrap.
    for (genvar g = 0; g < olid_pkg::CAPACITY; g++) begin : g_cell
        logic signed [olid_pkg::VAL_W-1:0] w_left;
        logic signed [olid_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end

        if (g == olid_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end

        olid_cell u_cell (
            .i_clk   (i_clk),
            .i_index (olid_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell_data[0]),
            .o_data  (w_cell_data[g])
        );
    end

    // Handshake: take a command only when idle and the result slot frees up.
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    assign w_full    = (r_count == olid_pkg::CNT_W'(olid_pkg::CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_m1  = i_cmd.position - olid_pkg::POS_W'(1);
    assign w_cnt_m1  = r_count - olid_pkg::CNT_W'(1);
    assign w_cnt_ext = olid_pkg::POS_W'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_count_out = r_count_out;
        n_value     = r_value;
        n_last      = r_last;

        w_ctl.op    = olid_pkg::CELL_HOLD;
        w_ctl.idx   = '0;
        w_ctl.count = r_count;
        w_ctl.value = i_cmd.value;

        priority if (w_take) begin
            n_out_valid = 1'b1;
            n_status    = olid_pkg::STAT_OK;
            n_value     = '0;
            n_last      = 1'b1;
            unique case (olid_pkg::t_cmd'(i_cmd.cmd))
                olid_pkg::CMD_INS_FRONT: begin
                    if (w_full) begin
                        n_status = olid_pkg::STAT_FULL;
                    end else begin
                        w_ctl.op  = olid_pkg::CELL_INSERT;
                        w_ctl.idx = '0;
                        n_count   = r_count + olid_pkg::CNT_W'(1);
                    end
                end
                olid_pkg::CMD_INS_BACK: begin
                    if (w_full) begin
                        n_status = olid_pkg::STAT_FULL;
                    end else begin
                        w_ctl.op  = olid_pkg::CELL_INSERT;
                        w_ctl.idx = r_count[olid_pkg::IDX_W-1:0];
                        n_count   = r_count + olid_pkg::CNT_W'(1);
                    end
                end
                olid_pkg::CMD_INS_AT: begin
                    // position check ranks above the full check
                    if (i_cmd.position == '0 ||
                        i_cmd.position > w_cnt_ext + olid_pkg::POS_W'(1)) begin
                        n_status = olid_pkg::STAT_BADPOS;
                    end else if (w_full) begin
                        n_status = olid_pkg::STAT_FULL;
                    end else begin
                        w_ctl.op  = olid_pkg::CELL_INSERT;
                        w_ctl.idx = w_pos_m1[olid_pkg::IDX_W-1:0];
                        n_count   = r_count + olid_pkg::CNT_W'(1);
                    end
                end
                olid_pkg::CMD_DEL_FRONT: begin
                    if (w_empty) begin
                        n_status = olid_pkg::STAT_EMPTY;
                    end else begin
                        w_ctl.op  = olid_pkg::CELL_DELETE;
                        w_ctl.idx = '0;
                        n_count   = w_cnt_m1;
                    end
                end
                olid_pkg::CMD_DEL_BACK: begin
                    if (w_empty) begin
                        n_status = olid_pkg::STAT_EMPTY;
                    end else begin
                        w_ctl.op  = olid_pkg::CELL_DELETE;
                        w_ctl.idx = w_cnt_m1[olid_pkg::IDX_W-1:0];
                        n_count   = w_cnt_m1;
                    end
                end
                olid_pkg::CMD_DEL_AT: begin
                    // an empty list has no valid position
                    if (i_cmd.position == '0 || i_cmd.position > w_cnt_ext) begin
                        n_status = olid_pkg::STAT_BADPOS;
                    end else begin
                        w_ctl.op  = olid_pkg::CELL_DELETE;
                        w_ctl.idx = w_pos_m1[olid_pkg::IDX_W-1:0];
                        n_count   = w_cnt_m1;
                    end
                end
                olid_pkg::CMD_DUMP: begin
                    if (w_empty) begin
                        n_status = olid_pkg::STAT_EMPTY;
                    end else begin
                        // hold the result slot; words stream from the dump state
                        n_out_valid = 1'b0;
                        n_left      = r_count;
                        n_state     = ST_DUMP;
                    end
                end
                default: begin
                    // unused command code: report ok, change nothing
                    n_status = olid_pkg::STAT_OK;
                end
            endcase
            n_count_out = n_count;
        end else if (r_state == ST_DUMP && w_out_free) begin
            // emit the head, rotate the chain, advance the remaining count
            n_out_valid = 1'b1;
            n_status    = olid_pkg::STAT_OK;
            n_count_out = r_count;
            n_value     = w_cell_data[0];
            n_last      = (r_left == olid_pkg::CNT_W'(1));
            w_ctl.op    = olid_pkg::CELL_ROTATE;
            n_left      = r_left - olid_pkg::CNT_W'(1);
            if (r_left == olid_pkg::CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_count_out <= n_count_out;
        r_value     <= n_value;
        r_last      <= n_last;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.element_count = r_count_out;
    assign o_res.element_value = r_value;
    assign o_res.last_flag     = r_last;

endmodule
